### sv/vec3_pkg.sv
// Shared types and constants for the three-component vector ALU.
package vec3_pkg;

    // default number format: signed Q16.16
    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int OP_WIDTH  = 3;
    localparam int VEC_LANES = 3;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD       = 3'd0,
        OP_SUB       = 3'd1,
        OP_DOT       = 3'd2,
        OP_SCALE     = 3'd3,
        OP_CROSS     = 3'd4,
        OP_NORM      = 3'd5,
        OP_NORMALIZE = 3'd6
    } op_t;

endpackage

### sv/vector3_alu_core.sv
// Top level of the three-component fixed-point vector ALU.
//
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    s_opcode, s_a_x/y/z, s_b_x/y/z, s_scale_factor
//  m_        out  m_valid/m_ready    m_out_x/y/z, m_out_scalar, m_saturated
//
// One request per cycle while the skid entry is free; depth grows with WORD_WIDTH
// and FRAC_BITS (Q16.16 default), set by the bit-per-stage square root and divider.
// Every opcode takes the same path, so results leave in request order.
// aresetn (synchronous) clears the valid bits only; data registers hold junk.
// A stalled output fills a one-entry skid, then s_ready drops and the whole
// pipeline freezes until the output is taken.
module vector3_alu_core
    import vec3_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [OP_WIDTH-1:0]          s_opcode,
    input  logic signed [WORD_WIDTH-1:0] s_a_x,
    input  logic signed [WORD_WIDTH-1:0] s_a_y,
    input  logic signed [WORD_WIDTH-1:0] s_a_z,
    input  logic signed [WORD_WIDTH-1:0] s_b_x,
    input  logic signed [WORD_WIDTH-1:0] s_b_y,
    input  logic signed [WORD_WIDTH-1:0] s_b_z,
    input  logic signed [WORD_WIDTH-1:0] s_scale_factor,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [WORD_WIDTH-1:0] m_out_x,
    output logic signed [WORD_WIDTH-1:0] m_out_y,
    output logic signed [WORD_WIDTH-1:0] m_out_z,
    output logic signed [WORD_WIDTH-1:0] m_out_scalar,
    output logic                         m_saturated
);

    localparam int W      = WORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int H      = (W + 1) / 2;
    localparam int PW     = 2 * W + 1;
    localparam int SW     = 2 * W + 3;
    localparam int CW     = 2 * W + 4;
    localparam int RES_W  = 4 * W + 1;
    localparam int SIDE_W = OP_WIDTH + 1 + 6 * W;
    localparam int STAG_W = OP_WIDTH + RES_W + 3 * W;
    localparam int DTAG_W = OP_WIDTH + RES_W + 4;
    localparam int NMUL   = 6;

    localparam logic signed [SW-1:0] HALF     = SW'(1) <<< (F - 1);
    localparam logic [W-1:0]         MAX_WORD = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]         MIN_WORD = {1'b1, {(W-1){1'b0}}};

    // clip to the word range: {saturated, value}
    function automatic logic [W:0] clip_fn(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] maxv;
        logic signed [CW-1:0] minv;
        logic [W:0]           r;
        maxv = CW'(signed'({1'b0, MAX_WORD}));
        minv = -maxv - CW'(1);
        if (v > maxv) begin
            r = {1'b1, MAX_WORD};
        end else if (v < minv) begin
            r = {1'b1, MIN_WORD};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    // magnitude; the most negative word maps to 2^(W-1)
    function automatic logic [W-1:0] mag_fn(input logic signed [W-1:0] v);
        logic [W-1:0] u;
        u = v;
        if (v[W-1]) begin
            u = ~u + 1'b1;
        end
        return u;
    endfunction

    logic en;
    logic skid_valid_reg;

    // pipeline advances whenever the skid entry is free
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    //--------------------------------------------------------------------
    // stage 1: input register
    //--------------------------------------------------------------------
    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    logic signed [W-1:0] s1_a_reg [3];
    logic signed [W-1:0] s1_b_reg [3];
    logic signed [W-1:0] s1_k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_op_reg   <= op_t'(s_opcode);
            s1_a_reg[0] <= s_a_x;
            s1_a_reg[1] <= s_a_y;
            s1_a_reg[2] <= s_a_z;
            s1_b_reg[0] <= s_b_x;
            s1_b_reg[1] <= s_b_y;
            s1_b_reg[2] <= s_b_z;
            s1_k_reg    <= s_scale_factor;
        end
    end

    // valid bits of stages 2 to 6
    logic [4:0] front_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= '0;
        end else if (en) begin
            front_valid_reg <= {front_valid_reg[3:0], s1_valid_reg};
        end
    end

    //--------------------------------------------------------------------
    // stage 2: multiplier operand select, add/subtract with clip
    //--------------------------------------------------------------------
    logic signed [W-1:0] opx [NMUL];
    logic signed [W-1:0] opy [NMUL];
    logic [W-1:0]        s2_mx_next [NMUL];
    logic [W-1:0]        s2_my_next [NMUL];
    logic                s2_neg_next [NMUL];
    logic signed [W:0]   as_sum [3];
    logic [W:0]          as_clip [3];
    logic [SIDE_W-1:0]   s2_side_next;

    always_comb begin
        for (int i = 0; i < NMUL; i++) begin
            opx[i] = '0;
            opy[i] = '0;
        end
        unique case (s1_op_reg)
            OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    opx[i] = s1_a_reg[i];
                    opy[i] = s1_b_reg[i];
                end
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    opx[i] = s1_a_reg[i];
                    opy[i] = s1_k_reg;
                end
            end
            OP_CROSS: begin
                opx[0] = s1_a_reg[1]; opy[0] = s1_b_reg[2];
                opx[1] = s1_a_reg[2]; opy[1] = s1_b_reg[1];
                opx[2] = s1_a_reg[2]; opy[2] = s1_b_reg[0];
                opx[3] = s1_a_reg[0]; opy[3] = s1_b_reg[2];
                opx[4] = s1_a_reg[0]; opy[4] = s1_b_reg[1];
                opx[5] = s1_a_reg[1]; opy[5] = s1_b_reg[0];
            end
            OP_NORM, OP_NORMALIZE: begin
                for (int i = 0; i < 3; i++) begin
                    opx[i] = s1_a_reg[i];
                    opy[i] = s1_a_reg[i];
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < NMUL; i++) begin
            s2_mx_next[i]  = mag_fn(opx[i]);
            s2_my_next[i]  = mag_fn(opy[i]);
            s2_neg_next[i] = opx[i][W-1] ^ opy[i][W-1];
        end
        for (int i = 0; i < 3; i++) begin
            if (s1_op_reg == OP_SUB) begin
                as_sum[i] = (W + 1)'(s1_a_reg[i]) - (W + 1)'(s1_b_reg[i]);
            end else begin
                as_sum[i] = (W + 1)'(s1_a_reg[i]) + (W + 1)'(s1_b_reg[i]);
            end
            as_clip[i] = clip_fn(CW'(as_sum[i]));
        end
        s2_side_next = {s1_op_reg, as_clip[0][W] | as_clip[1][W] | as_clip[2][W],
                        as_clip[0][W-1:0], as_clip[1][W-1:0], as_clip[2][W-1:0],
                        s1_a_reg[0], s1_a_reg[1], s1_a_reg[2]};
    end

    logic [W-1:0]      s2_mx_reg [NMUL];
    logic [W-1:0]      s2_my_reg [NMUL];
    logic              s2_neg_reg [NMUL];
    logic [SIDE_W-1:0] s2_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_mx_reg   <= s2_mx_next;
            s2_my_reg   <= s2_my_next;
            s2_neg_reg  <= s2_neg_next;
            s2_side_reg <= s2_side_next;
        end
    end

    //--------------------------------------------------------------------
    // stage 3: half-word partial products
    //--------------------------------------------------------------------
    logic [2*H-1:0]     s3_ll_next [NMUL];
    logic [W-1:0]       s3_lh_next [NMUL];
    logic [W-1:0]       s3_hl_next [NMUL];
    logic [2*(W-H)-1:0] s3_hh_next [NMUL];

    always_comb begin
        for (int i = 0; i < NMUL; i++) begin
            s3_ll_next[i] = (2 * H)'(s2_mx_reg[i][H-1:0]) * (2 * H)'(s2_my_reg[i][H-1:0]);
            s3_lh_next[i] = W'(s2_mx_reg[i][H-1:0]) * W'(s2_my_reg[i][W-1:H]);
            s3_hl_next[i] = W'(s2_mx_reg[i][W-1:H]) * W'(s2_my_reg[i][H-1:0]);
            s3_hh_next[i] = (2 * (W - H))'(s2_mx_reg[i][W-1:H])
                          * (2 * (W - H))'(s2_my_reg[i][W-1:H]);
        end
    end

    logic [2*H-1:0]     s3_ll_reg [NMUL];
    logic [W-1:0]       s3_lh_reg [NMUL];
    logic [W-1:0]       s3_hl_reg [NMUL];
    logic [2*(W-H)-1:0] s3_hh_reg [NMUL];
    logic               s3_neg_reg [NMUL];
    logic [SIDE_W-1:0]  s3_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_ll_reg   <= s3_ll_next;
            s3_lh_reg   <= s3_lh_next;
            s3_hl_reg   <= s3_hl_next;
            s3_hh_reg   <= s3_hh_next;
            s3_neg_reg  <= s2_neg_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    //--------------------------------------------------------------------
    // stage 4: partial-product sum and sign
    //--------------------------------------------------------------------
    logic [2*W-1:0]       magp [NMUL];
    logic signed [PW-1:0] pm [NMUL];
    logic signed [PW-1:0] s4_p_next [NMUL];

    always_comb begin
        for (int i = 0; i < NMUL; i++) begin
            magp[i] = ((2 * W)'(s3_hh_reg[i]) << (2 * H))
                    + ((2 * W)'(s3_lh_reg[i]) << H)
                    + ((2 * W)'(s3_hl_reg[i]) << H)
                    + (2 * W)'(s3_ll_reg[i]);
            pm[i]        = signed'({1'b0, magp[i]});
            s4_p_next[i] = s3_neg_reg[i] ? -pm[i] : pm[i];
        end
    end

    logic signed [PW-1:0] s4_p_reg [NMUL];
    logic [SIDE_W-1:0]    s4_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_p_reg    <= s4_p_next;
            s4_side_reg <= s3_side_reg;
        end
    end

    //--------------------------------------------------------------------
    // stage 5: combine products per operation
    //--------------------------------------------------------------------
    op_t                  s4_op;
    logic signed [SW-1:0] ext [NMUL];
    logic signed [SW-1:0] s5_w_next [3];

    assign s4_op = op_t'(s4_side_reg[SIDE_W-1 -: OP_WIDTH]);

    always_comb begin
        for (int i = 0; i < NMUL; i++) begin
            ext[i] = SW'(s4_p_reg[i]);
        end
        for (int i = 0; i < 3; i++) begin
            s5_w_next[i] = '0;
        end
        unique case (s4_op)
            OP_DOT, OP_NORM, OP_NORMALIZE: begin
                s5_w_next[0] = ext[0] + ext[1] + ext[2];
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    s5_w_next[i] = ext[i];
                end
            end
            OP_CROSS: begin
                s5_w_next[0] = ext[0] - ext[1];
                s5_w_next[1] = ext[2] - ext[3];
                s5_w_next[2] = ext[4] - ext[5];
            end
            default: begin
            end
        endcase
    end

    logic signed [SW-1:0] s5_w_reg [3];
    logic [SIDE_W-1:0]    s5_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_w_reg    <= s5_w_next;
            s5_side_reg <= s4_side_reg;
        end
    end

    //--------------------------------------------------------------------
    // stage 6: round half up to FRAC_BITS, clip, pick front-end result
    //--------------------------------------------------------------------
    op_t                  s5_op;
    logic signed [SW-1:0] rs [3];
    logic [W:0]           rc [3];
    logic [RES_W-1:0]     s6_res_next;
    logic [STAG_W-1:0]    s6_tag_next;

    assign s5_op = op_t'(s5_side_reg[SIDE_W-1 -: OP_WIDTH]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rs[i] = (s5_w_reg[i] + HALF) >>> F;
            rc[i] = clip_fn(CW'(rs[i]));
        end
        s6_res_next = '0;
        unique case (s5_op)
            OP_ADD, OP_SUB: begin
                s6_res_next = {s5_side_reg[6*W-1:3*W], W'(0), s5_side_reg[6*W]};
            end
            OP_DOT: begin
                s6_res_next = {(3 * W)'(0), rc[0][W-1:0], rc[0][W]};
            end
            OP_SCALE, OP_CROSS: begin
                s6_res_next = {rc[0][W-1:0], rc[1][W-1:0], rc[2][W-1:0], W'(0),
                               rc[0][W] | rc[1][W] | rc[2][W]};
            end
            default: begin
            end
        endcase
        s6_tag_next = {s5_op, s6_res_next, s5_side_reg[3*W-1:0]};
    end

    logic [STAG_W-1:0] s6_tag_reg;
    logic [2*W-1:0]    s6_rad_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_tag_reg <= s6_tag_next;
            s6_rad_reg <= s5_w_reg[0][2*W-1:0];
        end
    end

    //--------------------------------------------------------------------
    // square root of the sum of squares
    //--------------------------------------------------------------------
    logic              sq_valid;
    logic [W-1:0]      sq_root;
    logic [W:0]        sq_rem;
    logic [STAG_W-1:0] sq_tag;

    vec3_sqrt #(
        .WORD_WIDTH (W),
        .TAG_W      (STAG_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid_reg[4]),
        .in_rad    (s6_rad_reg),
        .in_tag    (s6_tag_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_rem   (sq_rem),
        .out_tag   (sq_tag)
    );

    //--------------------------------------------------------------------
    // root rounding, norm result, divider operands
    //--------------------------------------------------------------------
    op_t                 sq_op;
    logic [RES_W-1:0]    sq_res;
    logic signed [W-1:0] sq_a [3];
    logic [W:0]          rnd_root;
    logic [W:0]          norm_clip;
    logic [RES_W-1:0]    r_res_next;
    logic [DTAG_W-1:0]   r_tag_next;
    logic [W+F-1:0]      r_num_next [VEC_LANES];

    assign sq_op   = op_t'(sq_tag[STAG_W-1 -: OP_WIDTH]);
    assign sq_res  = sq_tag[3*W +: RES_W];
    assign sq_a[0] = sq_tag[3*W-1:2*W];
    assign sq_a[1] = sq_tag[2*W-1:W];
    assign sq_a[2] = sq_tag[W-1:0];

    always_comb begin
        rnd_root  = {1'b0, sq_root} + (W + 1)'(sq_rem > {1'b0, sq_root});
        norm_clip = clip_fn(CW'(signed'({1'b0, rnd_root})));
        r_res_next = sq_res;
        if (sq_op == OP_NORM) begin
            r_res_next = {(3 * W)'(0), norm_clip[W-1:0], norm_clip[W]};
        end
        r_tag_next = {sq_op, r_res_next,
                      (sq_a[0] == '0) && (sq_a[1] == '0) && (sq_a[2] == '0),
                      sq_a[0][W-1], sq_a[1][W-1], sq_a[2][W-1]};
        for (int l = 0; l < VEC_LANES; l++) begin
            r_num_next[l] = {mag_fn(sq_a[l]), F'(0)};
        end
    end

    logic              r_valid_reg;
    logic [DTAG_W-1:0] r_tag_reg;
    logic [W:0]        r_den_reg;
    logic [W+F-1:0]    r_num_reg [VEC_LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (en) begin
            r_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_tag_reg <= r_tag_next;
            r_den_reg <= rnd_root;
            r_num_reg <= r_num_next;
        end
    end

    //--------------------------------------------------------------------
    // component / norm division
    //--------------------------------------------------------------------
    logic              dv_valid;
    logic [F:0]        dv_quo [VEC_LANES];
    logic [W:0]        dv_rem [VEC_LANES];
    logic [W:0]        dv_den;
    logic [DTAG_W-1:0] dv_tag;

    vec3_div #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (F),
        .TAG_W      (DTAG_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid_reg),
        .in_num    (r_num_reg),
        .in_den    (r_den_reg),
        .in_tag    (r_tag_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_rem   (dv_rem),
        .out_den   (dv_den),
        .out_tag   (dv_tag)
    );

    //--------------------------------------------------------------------
    // quotient rounding, sign, clip; final result select
    //--------------------------------------------------------------------
    op_t                   dv_op;
    logic                  dv_zero;
    logic                  dv_up [VEC_LANES];
    logic [F+1:0]          qr [VEC_LANES];
    logic signed [F+2:0]   qs [VEC_LANES];
    logic [W:0]            qc [VEC_LANES];
    logic [RES_W-1:0]      fin_data;

    assign dv_op   = op_t'(dv_tag[DTAG_W-1 -: OP_WIDTH]);
    assign dv_zero = dv_tag[3];

    always_comb begin
        for (int l = 0; l < VEC_LANES; l++) begin
            dv_up[l] = {dv_rem[l], 1'b0} >= {1'b0, dv_den};
            qr[l]    = (F + 2)'(dv_quo[l]) + (F + 2)'(dv_up[l]);
            qs[l]    = signed'({1'b0, qr[l]});
            if (dv_tag[2-l]) begin
                qs[l] = -qs[l];
            end
            qc[l] = clip_fn(CW'(qs[l]));
        end
        fin_data = dv_tag[4 +: RES_W];
        // a zero vector keeps the all-zero result from the front end
        if (dv_op == OP_NORMALIZE && !dv_zero) begin
            fin_data = {qc[0][W-1:0], qc[1][W-1:0], qc[2][W-1:0], W'(0),
                        qc[0][W] | qc[1][W] | qc[2][W]};
        end
    end

    //--------------------------------------------------------------------
    // output register with one-entry skid
    //--------------------------------------------------------------------
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             skid_valid_next;
    logic [RES_W-1:0] out_data_reg;
    logic [RES_W-1:0] out_data_next;
    logic [RES_W-1:0] skid_data_reg;
    logic [RES_W-1:0] skid_data_next;
    logic             push;

    assign push = dv_valid && en;

    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                m_valid_next    = 1'b1;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_data_next = fin_data;
                m_valid_next  = 1'b1;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (push) begin
            skid_data_next  = fin_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_x      = out_data_reg[RES_W-1 -: W];
    assign m_out_y      = out_data_reg[3*W:2*W+1];
    assign m_out_z      = out_data_reg[2*W:W+1];
    assign m_out_scalar = out_data_reg[W:1];
    assign m_saturated  = out_data_reg[0];

`ifndef SYNTH
    // skid holds a request only behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid with empty output register");

    // skid keeps its request while the output stays blocked
    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_ready |=> skid_valid_reg)
        else $error("skid request lost under stall");

    // skid only fills when the output register was blocked
    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid filled without output stall");

    // a clipped result shows at least one value at a range end
    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_saturated |->
            (m_out_x == MAX_WORD) || (m_out_x == MIN_WORD) ||
            (m_out_y == MAX_WORD) || (m_out_y == MIN_WORD) ||
            (m_out_z == MAX_WORD) || (m_out_z == MIN_WORD) ||
            (m_out_scalar == MAX_WORD) || (m_out_scalar == MIN_WORD))
        else $error("saturated flag without clipped value");
`endif

endmodule

### sv/vec3_sqrt.sv
// Pipelined integer square root, one root bit per stage, with remainder.
module vec3_sqrt
    import vec3_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int TAG_W      = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2*WORD_WIDTH-1:0] in_rad,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic [WORD_WIDTH-1:0]   out_root,
    output logic [WORD_WIDTH:0]     out_rem,
    output logic [TAG_W-1:0]        out_tag
);

    localparam int W  = WORD_WIDTH;
    localparam int NW = 2 * W;
    localparam int RW = 2 * W + 1;

    logic [W-1:0]     valid_reg;
    logic [NW-1:0]    num_reg  [W];
    logic [RW-1:0]    res_reg  [W];
    logic [TAG_W-1:0] tag_reg  [W];

    logic [NW-1:0]    num_src  [W];
    logic [RW-1:0]    res_src  [W];
    logic [TAG_W-1:0] tag_src  [W];
    logic [NW-1:0]    num_next [W];
    logic [RW-1:0]    res_next [W];

    // one trial subtraction per stage, highest root bit first
    always_comb begin
        logic [RW-1:0] one;
        logic [RW-1:0] trial;
        num_src[0] = in_rad;
        res_src[0] = '0;
        tag_src[0] = in_tag;
        for (int k = 1; k < W; k++) begin
            num_src[k] = num_reg[k-1];
            res_src[k] = res_reg[k-1];
            tag_src[k] = tag_reg[k-1];
        end
        for (int k = 0; k < W; k++) begin
            one   = RW'(1) << (2 * (W - 1 - k));
            trial = res_src[k] + one;
            if ({1'b0, num_src[k]} >= trial) begin
                num_next[k] = num_src[k] - trial[NW-1:0];
                res_next[k] = (res_src[k] >> 1) + one;
            end else begin
                num_next[k] = num_src[k];
                res_next[k] = res_src[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_next;
            res_reg <= res_next;
            tag_reg <= tag_src;
        end
    end

    assign out_valid = valid_reg[W-1];
    assign out_root  = res_reg[W-1][W-1:0];
    assign out_rem   = num_reg[W-1][W:0];
    assign out_tag   = tag_reg[W-1];

endmodule

### sv/vec3_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module vec3_div
    import vec3_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int TAG_W      = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [WORD_WIDTH+FRAC_BITS-1:0] in_num [VEC_LANES],
    input  logic [WORD_WIDTH:0]             in_den,
    input  logic [TAG_W-1:0]                in_tag,
    output logic                            out_valid,
    output logic [FRAC_BITS:0]              out_quo [VEC_LANES],
    output logic [WORD_WIDTH:0]             out_rem [VEC_LANES],
    output logic [WORD_WIDTH:0]             out_den,
    output logic [TAG_W-1:0]                out_tag
);

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int NS  = F + 1;
    localparam int RMW = W + F + 1;

    logic [NS-1:0]    valid_reg;
    logic [RMW-1:0]   rem_reg  [NS][VEC_LANES];
    logic [F:0]       quo_reg  [NS][VEC_LANES];
    logic [W:0]       den_reg  [NS];
    logic [TAG_W-1:0] tag_reg  [NS];

    logic [RMW-1:0]   rem_src  [NS][VEC_LANES];
    logic [F:0]       quo_src  [NS][VEC_LANES];
    logic [W:0]       den_src  [NS];
    logic [TAG_W-1:0] tag_src  [NS];
    logic [RMW-1:0]   rem_next [NS][VEC_LANES];
    logic [F:0]       quo_next [NS][VEC_LANES];

    // quotient fits in FRAC_BITS+1 bits since the divisor is at least the component magnitude
    always_comb begin
        logic [RMW-1:0] dsh;
        for (int l = 0; l < VEC_LANES; l++) begin
            rem_src[0][l] = RMW'(in_num[l]);
            quo_src[0][l] = '0;
        end
        den_src[0] = in_den;
        tag_src[0] = in_tag;
        for (int k = 1; k < NS; k++) begin
            rem_src[k] = rem_reg[k-1];
            quo_src[k] = quo_reg[k-1];
            den_src[k] = den_reg[k-1];
            tag_src[k] = tag_reg[k-1];
        end
        for (int k = 0; k < NS; k++) begin
            dsh = RMW'(den_src[k]) << (F - k);
            for (int l = 0; l < VEC_LANES; l++) begin
                if (rem_src[k][l] >= dsh) begin
                    rem_next[k][l] = rem_src[k][l] - dsh;
                    quo_next[k][l] = quo_src[k][l] | ((F + 1)'(1) << (F - k));
                end else begin
                    rem_next[k][l] = rem_src[k][l];
                    quo_next[k][l] = quo_src[k][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den_src;
            tag_reg <= tag_src;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_den   = den_reg[NS-1];
    assign out_tag   = tag_reg[NS-1];

    always_comb begin
        for (int l = 0; l < VEC_LANES; l++) begin
            out_quo[l] = quo_reg[NS-1][l];
            out_rem[l] = rem_reg[NS-1][l][W:0];
        end
    end

endmodule
